// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, off while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/tqle_pkg.sv =====
`timescale 1ns / 1ps

package tqle_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;
	localparam int ACT_IDX_W  = 4;
	localparam int Q_W        = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE_RATE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS         = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIONS      = 3'd5;

	localparam logic [16:0] EXPLORE_RST  = 17'd0;
	localparam logic [15:0] LEARN_RST    = 16'd655;
	localparam logic [15:0] DISCOUNT_RST = 16'd64881;
	localparam logic [4:0]  ROWS_RST     = 5'd16;
	localparam logic [4:0]  COLS_RST     = 5'd16;
	localparam logic [3:0]  ACTIONS_RST  = 4'd4;

	localparam logic REQ_ACTION = 1'b0;
	localparam logic REQ_UPDATE = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_DRAIN,
		ST_MUL_D,
		ST_CALC_E,
		ST_MUL_S,
		ST_APPLY,
		ST_FINISH
	} ctrl_state_t;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_Q,
		RD_SCAN_FIRST,
		RD_SCAN_NEXT
	} rd_tag_t;

	typedef struct packed {
		logic                 capture;
		logic                 clear_step;
		rd_tag_t              rd_tag;
		logic [ACT_IDX_W-1:0] scan_act;
		logic                 mul_d;
		logic                 calc_e;
		logic                 mul_s;
		logic                 apply;
		logic                 load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic bad;
		logic explore_hit;
		logic is_update;
		logic scan_last;
	} dp_status_t;

endpackage

// ===== rtl/tqle_ram.sv =====
`timescale 1ns / 1ps

module tqle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/tqle_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tqle_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  logic                  out_stall,
	output tqle_pkg::dp_cmd_t     cmd,
	input  tqle_pkg::dp_status_t  status
);

	tqle_pkg::ctrl_state_t                state_q;
	tqle_pkg::ctrl_state_t                state_d;
	logic [tqle_pkg::ACT_IDX_W-1:0]       cnt_q;
	logic                                 out_valid_q;
	logic                                 out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			tqle_pkg::ST_CLEAR: begin
				if (status.clear_last) begin
					state_d = tqle_pkg::ST_IDLE;
				end
			end
			tqle_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = tqle_pkg::ST_CHECK;
				end
			end
			tqle_pkg::ST_CHECK: begin
				if (status.bad || (!status.is_update && status.explore_hit)) begin
					state_d = tqle_pkg::ST_FINISH;
				end else begin
					state_d = tqle_pkg::ST_SCAN;
				end
			end
			tqle_pkg::ST_SCAN: begin
				if (status.scan_last) begin
					state_d = tqle_pkg::ST_DRAIN;
				end
			end
			tqle_pkg::ST_DRAIN: begin
				state_d = status.is_update ? tqle_pkg::ST_MUL_D : tqle_pkg::ST_FINISH;
			end
			tqle_pkg::ST_MUL_D:  state_d = tqle_pkg::ST_CALC_E;
			tqle_pkg::ST_CALC_E: state_d = tqle_pkg::ST_MUL_S;
			tqle_pkg::ST_MUL_S:  state_d = tqle_pkg::ST_APPLY;
			tqle_pkg::ST_APPLY:  state_d = tqle_pkg::ST_FINISH;
			tqle_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = tqle_pkg::ST_IDLE;
				end
			end
			default: state_d = tqle_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			tqle_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
			tqle_pkg::ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			tqle_pkg::ST_CHECK: begin
				if (!status.bad && status.is_update) begin
					cmd.rd_tag = tqle_pkg::RD_Q;
				end
			end
			tqle_pkg::ST_SCAN: begin
				cmd.scan_act = cnt_q;
				cmd.rd_tag   = (cnt_q == '0) ? tqle_pkg::RD_SCAN_FIRST : tqle_pkg::RD_SCAN_NEXT;
			end
			tqle_pkg::ST_MUL_D:  cmd.mul_d    = 1'b1;
			tqle_pkg::ST_CALC_E: cmd.calc_e   = 1'b1;
			tqle_pkg::ST_MUL_S:  cmd.mul_s    = 1'b1;
			tqle_pkg::ST_APPLY:  cmd.apply    = 1'b1;
			tqle_pkg::ST_FINISH: cmd.load_out = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tqle_pkg::ST_CLEAR;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == tqle_pkg::ST_CHECK) begin
				cnt_q <= '0;
			end else if (state_q == tqle_pkg::ST_SCAN) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// a word only shows up after the finish step
	`ASSERT_IMPLY(a_out_from_finish, clk, arst_n, $rose(out_valid_q),
		$past(state_q) == tqle_pkg::ST_FINISH)

	// nothing taken in before the table is cleared
	`ASSERT_IMPLY(a_no_accept_in_clear, clk, arst_n, state_q == tqle_pkg::ST_CLEAR,
		in_stall && !cmd.capture && !out_valid_q)

endmodule

// ===== rtl/tqle_dp.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tqle_dp #(
	parameter int MAX_ROWS    = 16,
	parameter int MAX_COLS    = 16,
	parameter int MAX_ACTIONS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tqle_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tqle_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              req_type,
	input  logic [3:0]                        cell_row,
	input  logic [3:0]                        cell_col,
	input  logic [2:0]                        taken_action,
	input  logic signed [15:0]                reward_value,
	input  logic [3:0]                        next_row,
	input  logic [3:0]                        next_col,
	input  logic [15:0]                       uniform_draw,
	input  logic [2:0]                        random_choice,
	input  tqle_pkg::dp_cmd_t                 cmd,
	output tqle_pkg::dp_status_t              status,
	output logic [2:0]                        chosen_action,
	output logic                              explored,
	output logic signed [31:0]                updated_q,
	output logic                              bad_request
);

	localparam int DEPTH  = MAX_ROWS * MAX_COLS * MAX_ACTIONS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [8:0] ROWS_MAX = 9'(MAX_ROWS);
	localparam logic [8:0] COLS_MAX = 9'(MAX_COLS);
	localparam logic [4:0] ACTS_MAX = 5'(MAX_ACTIONS);
	localparam logic signed [35:0] V_MAX = 36'sd2147483647;
	localparam logic signed [35:0] V_MIN = -36'sd2147483648;

	logic [16:0] explore_q;
	logic [15:0] learn_q;
	logic [15:0] discount_q;
	logic [4:0]  rows_q;
	logic [4:0]  cols_q;
	logic [3:0]  actions_q;

	logic               req_q;
	logic [3:0]         row_q;
	logic [3:0]         col_q;
	logic [2:0]         act_q;
	logic signed [15:0] reward_q;
	logic [3:0]         nrow_q;
	logic [3:0]         ncol_q;
	logic [15:0]        draw_q;
	logic [2:0]         pick_q;

	logic [4:0] na_eff;
	logic       is_upd;
	logic       row_bad, col_bad, nrow_bad, ncol_bad, act_bad, pick_bad;
	logic       explore_hit;
	logic       bad_w;

	logic [ADDR_W-1:0] clr_q;
	logic [3:0]        scan_row;
	logic [3:0]        scan_col;
	logic [ADDR_W-1:0] scan_base;
	logic [ADDR_W-1:0] upd_idx;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [31:0]       ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [31:0]       ram_rdata;

	tqle_pkg::rd_tag_t              tag_s1;
	logic [tqle_pkg::ACT_IDX_W-1:0] act_s1;

	logic signed [31:0]             q_q;
	logic signed [31:0]             best_val_q;
	logic [tqle_pkg::ACT_IDX_W-1:0] best_idx_q;
	logic signed [48:0]             prod_d_q;
	logic signed [32:0]             d_w;
	logic signed [33:0]             e_next;
	logic signed [33:0]             e_q;
	logic signed [50:0]             prod_s_q;
	logic signed [34:0]             s_w;
	logic signed [35:0]             v_wide;
	logic signed [31:0]             v_sat;
	logic signed [31:0]             v_q;

	logic [2:0]         chosen_q;
	logic               explored_q;
	logic signed [31:0] updated_q_q;
	logic               bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			explore_q  <= tqle_pkg::EXPLORE_RST;
			learn_q    <= tqle_pkg::LEARN_RST;
			discount_q <= tqle_pkg::DISCOUNT_RST;
			rows_q     <= tqle_pkg::ROWS_RST;
			cols_q     <= tqle_pkg::COLS_RST;
			actions_q  <= tqle_pkg::ACTIONS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tqle_pkg::CFG_EXPLORE_RATE: explore_q  <= cfg_data[16:0];
				tqle_pkg::CFG_LEARN_RATE:   learn_q    <= cfg_data[15:0];
				tqle_pkg::CFG_DISCOUNT:     discount_q <= cfg_data[15:0];
				tqle_pkg::CFG_ROWS:         rows_q     <= cfg_data[4:0];
				tqle_pkg::CFG_COLS:         cols_q     <= cfg_data[4:0];
				tqle_pkg::CFG_ACTIONS:      actions_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q    <= req_type;
			row_q    <= cell_row;
			col_q    <= cell_col;
			act_q    <= taken_action;
			reward_q <= reward_value;
			nrow_q   <= next_row;
			ncol_q   <= next_col;
			draw_q   <= uniform_draw;
			pick_q   <= random_choice;
		end
	end

	// request checks against the sizes in use
	assign na_eff      = ({1'b0, actions_q} > ACTS_MAX) ? ACTS_MAX : {1'b0, actions_q};
	assign is_upd      = (req_q == tqle_pkg::REQ_UPDATE);
	assign row_bad     = ({1'b0, row_q} >= rows_q) || ({5'b0, row_q} >= ROWS_MAX);
	assign col_bad     = ({1'b0, col_q} >= cols_q) || ({5'b0, col_q} >= COLS_MAX);
	assign nrow_bad    = ({1'b0, nrow_q} >= rows_q) || ({5'b0, nrow_q} >= ROWS_MAX);
	assign ncol_bad    = ({1'b0, ncol_q} >= cols_q) || ({5'b0, ncol_q} >= COLS_MAX);
	assign act_bad     = ({2'b0, act_q} >= na_eff);
	assign pick_bad    = ({2'b0, pick_q} >= na_eff);
	assign explore_hit = ({1'b0, draw_q} <= explore_q);
	assign bad_w = row_bad || col_bad || (na_eff == 5'd0) ||
		(is_upd ? (nrow_bad || ncol_bad || act_bad) : (explore_hit && pick_bad));

	assign status.clear_last  = (clr_q == ADDR_W'(DEPTH - 1));
	assign status.bad         = bad_w;
	assign status.explore_hit = explore_hit;
	assign status.is_update   = is_upd;
	assign status.scan_last   = (5'(cmd.scan_act) == (na_eff - 5'd1));

	// table addressing
	assign scan_row  = is_upd ? nrow_q : row_q;
	assign scan_col  = is_upd ? ncol_q : col_q;
	assign scan_base = ADDR_W'((int'(scan_row) * MAX_COLS + int'(scan_col)) * MAX_ACTIONS);
	assign upd_idx   = ADDR_W'((int'(row_q) * MAX_COLS + int'(col_q)) * MAX_ACTIONS
		+ int'(act_q));

	assign ram_we    = cmd.clear_step || cmd.apply;
	assign ram_waddr = cmd.clear_step ? clr_q : upd_idx;
	assign ram_wdata = cmd.clear_step ? 32'd0 : v_sat;
	assign ram_re    = (cmd.rd_tag != tqle_pkg::RD_NONE);
	assign ram_raddr = (cmd.rd_tag == tqle_pkg::RD_Q) ? upd_idx
		: (scan_base + ADDR_W'(cmd.scan_act));

	tqle_ram #(
		.WIDTH (tqle_pkg::Q_W),
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			tag_s1 <= tqle_pkg::RD_NONE;
		end else begin
			if (cmd.clear_step) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			tag_s1 <= cmd.rd_tag;
		end
	end

	always_ff @(posedge clk) begin
		act_s1 <= cmd.scan_act;
	end

	// read-back: current entry and running maximum of the scanned cell
	always_ff @(posedge clk) begin
		case (tag_s1)
			tqle_pkg::RD_Q: q_q <= $signed(ram_rdata);
			tqle_pkg::RD_SCAN_FIRST: begin
				best_val_q <= $signed(ram_rdata);
				best_idx_q <= act_s1;
			end
			tqle_pkg::RD_SCAN_NEXT: begin
				if ($signed(ram_rdata) > best_val_q) begin
					best_val_q <= $signed(ram_rdata);
					best_idx_q <= act_s1;
				end
			end
			default: ;
		endcase
	end

	// update arithmetic, rounding halves up
	assign d_w    = 33'((prod_d_q + 49'sd32768) >>> 16);
	assign e_next = $signed({reward_q, 16'h0000}) + d_w - q_q;
	assign s_w    = 35'((prod_s_q + 51'sd32768) >>> 16);
	assign v_wide = s_w + q_q;
	assign v_sat  = (v_wide > V_MAX) ? V_MAX[31:0]
		: ((v_wide < V_MIN) ? V_MIN[31:0] : v_wide[31:0]);

	always_ff @(posedge clk) begin
		if (cmd.mul_d) begin
			prod_d_q <= $signed({1'b0, discount_q}) * best_val_q;
		end
		if (cmd.calc_e) begin
			e_q <= e_next;
		end
		if (cmd.mul_s) begin
			prod_s_q <= $signed({1'b0, learn_q}) * e_q;
		end
		if (cmd.apply) begin
			v_q <= v_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			if (bad_w) begin
				chosen_q    <= 3'd0;
				explored_q  <= 1'b0;
				updated_q_q <= 32'sd0;
				bad_q       <= 1'b1;
			end else if (is_upd) begin
				chosen_q    <= 3'd0;
				explored_q  <= 1'b0;
				updated_q_q <= v_q;
				bad_q       <= 1'b0;
			end else if (explore_hit) begin
				chosen_q    <= pick_q;
				explored_q  <= 1'b1;
				updated_q_q <= 32'sd0;
				bad_q       <= 1'b0;
			end else begin
				chosen_q    <= best_idx_q[2:0];
				explored_q  <= 1'b0;
				updated_q_q <= 32'sd0;
				bad_q       <= 1'b0;
			end
		end
	end

	assign chosen_action = chosen_q;
	assign explored      = explored_q;
	assign updated_q     = updated_q_q;
	assign bad_request   = bad_q;

	// outside the clearing pass, only a checked transition may write the table
	`ASSERT_IMPLY(a_apply_only_good_update, clk, arst_n, cmd.apply, is_upd && !bad_w)

	// the scan never walks past the actions in use
	`ASSERT_IMPLY(a_scan_in_cell, clk, arst_n,
		(cmd.rd_tag == tqle_pkg::RD_SCAN_FIRST) || (cmd.rd_tag == tqle_pkg::RD_SCAN_NEXT),
		5'(cmd.scan_act) < na_eff)

endmodule

// ===== rtl/tabular_q_learning_engine.sv =====
// Tabular Q-learning engine with epsilon-greedy action choice. The Q-table
// (MAX_ROWS*MAX_COLS*MAX_ACTIONS signed Q16.16 entries) lives in one
// single-port-read memory; after reset a clearing pass writes one entry per
// cycle, and the block stalls its input until the pass is done, while
// configuration writes are still taken. One request is worked at a time: a
// bad request or an exploring action request is answered without a table
// read, a greedy action request first finds the argmax of its cell, and a
// transition finds the argmax of the next cell. The argmax walks the actions
// in use one table read per cycle; for a transition, two registered multiplies
// and a saturating write-back follow. A finished word waits in an output
// register, so the next request is taken while it is still stalled.
`timescale 1ns / 1ps

module tabular_q_learning_engine #(
	parameter int MAX_ROWS    = 16,
	parameter int MAX_COLS    = 16,
	parameter int MAX_ACTIONS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tqle_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tqle_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            req_type,
	input  logic [3:0]                      cell_row,
	input  logic [3:0]                      cell_col,
	input  logic [2:0]                      taken_action,
	input  logic signed [15:0]              reward_value,
	input  logic [3:0]                      next_row,
	input  logic [3:0]                      next_col,
	input  logic [15:0]                     uniform_draw,
	input  logic [2:0]                      random_choice,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [2:0]                      chosen_action,
	output logic                            explored,
	output logic signed [31:0]              updated_q,
	output logic                            bad_request
);

	tqle_pkg::dp_cmd_t    cmd;
	tqle_pkg::dp_status_t status;

	tqle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	tqle_dp #(
		.MAX_ROWS    (MAX_ROWS),
		.MAX_COLS    (MAX_COLS),
		.MAX_ACTIONS (MAX_ACTIONS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.req_type      (req_type),
		.cell_row      (cell_row),
		.cell_col      (cell_col),
		.taken_action  (taken_action),
		.reward_value  (reward_value),
		.next_row      (next_row),
		.next_col      (next_col),
		.uniform_draw  (uniform_draw),
		.random_choice (random_choice),
		.cmd           (cmd),
		.status        (status),
		.chosen_action (chosen_action),
		.explored      (explored),
		.updated_q     (updated_q),
		.bad_request   (bad_request)
	);

endmodule

// ===== bench/q_engine_monitor.sv =====
`timescale 1ns / 1ps

module q_engine_monitor (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tqle_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tqle_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic                            req_type,
	input  logic [3:0]                      cell_row,
	input  logic [3:0]                      cell_col,
	input  logic [2:0]                      taken_action,
	input  logic signed [15:0]              reward_value,
	input  logic [3:0]                      next_row,
	input  logic [3:0]                      next_col,
	input  logic [15:0]                     uniform_draw,
	input  logic [2:0]                      random_choice,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic [2:0]                      chosen_action,
	input  logic                            explored,
	input  logic signed [31:0]              updated_q,
	input  logic                            bad_request,
	output int                              mismatches,
	output int                              pending
);

	localparam int unsigned MAX_ROWS    = 16;
	localparam int unsigned MAX_COLS    = 16;
	localparam int unsigned MAX_ACTIONS = 8;
	localparam int unsigned DEPTH       = MAX_ROWS * MAX_COLS * MAX_ACTIONS;
	localparam longint      Q_HIGH      = 64'sd2147483647;
	localparam longint      Q_LOW       = -64'sd2147483648;

	typedef struct packed {
		logic [2:0]         action;
		logic               explored;
		logic signed [31:0] q;
		logic               bad;
	} response_t;

	logic signed [31:0] q_mem [0:DEPTH-1];
	logic [16:0]        explore_rate;
	logic [15:0]        learn_rate;
	logic [15:0]        discount;
	logic [4:0]         rows_in_use;
	logic [4:0]         cols_in_use;
	logic [3:0]         actions_in_use;
	response_t          expected_responses [$];
	response_t          got;
	response_t          want;
	int                 entry;

	// floor(x / 2^16 + 0.5), halves go up
	function automatic longint round_q16(input longint x);
		return (x + 64'sd32768) >>> 16;
	endfunction

	function automatic int unsigned clamp(input int unsigned v, input int unsigned lim);
		return (v > lim) ? lim : v;
	endfunction

	// argmax over the first n actions, ties to the lowest index
	function automatic int unsigned greedy_action(input int unsigned base, input int unsigned n);
		int unsigned best;
		int unsigned a;
		best = 0;
		for (a = 1; a < n; a++)
			if (q_mem[base + a] > q_mem[base + best])
				best = a;
		return best;
	endfunction

	function automatic response_t predict_response(
		input logic               rq,
		input logic [3:0]         row,
		input logic [3:0]         col,
		input logic [2:0]         act,
		input logic signed [15:0] reward,
		input logic [3:0]         nxt_row,
		input logic [3:0]         nxt_col,
		input logic [15:0]        draw,
		input logic [2:0]         pick
	);
		response_t   res;
		int unsigned nrows;
		int unsigned ncols;
		int unsigned nacts;
		int unsigned base;
		int unsigned nbase;
		longint      qmax;
		longint      qold;
		longint      disc;
		longint      err;
		longint      val;
		res = '0;
		nrows = clamp(rows_in_use, MAX_ROWS);
		ncols = clamp(cols_in_use, MAX_COLS);
		nacts = clamp(actions_in_use, MAX_ACTIONS);
		base = (row * MAX_COLS + col) * MAX_ACTIONS;
		if (row >= nrows || col >= ncols || nacts == 0) begin
			res.bad = 1'b1;
		end else if (rq == tqle_pkg::REQ_ACTION) begin
			if ({1'b0, draw} <= explore_rate) begin
				if (pick >= nacts) begin
					res.bad = 1'b1;
				end else begin
					res.action = pick;
					res.explored = 1'b1;
				end
			end else begin
				res.action = 3'(greedy_action(base, nacts));
			end
		end else if (nxt_row >= nrows || nxt_col >= ncols || act >= nacts) begin
			res.bad = 1'b1;
		end else begin
			nbase = (nxt_row * MAX_COLS + nxt_col) * MAX_ACTIONS;
			qmax = longint'(q_mem[nbase + greedy_action(nbase, nacts)]);
			qold = longint'(q_mem[base + act]);
			disc = round_q16(longint'(discount) * qmax);
			err = longint'(reward) * 65536 + disc - qold;
			val = qold + round_q16(longint'(learn_rate) * err);
			if (val > Q_HIGH)
				val = Q_HIGH;
			if (val < Q_LOW)
				val = Q_LOW;
			q_mem[base + act] = 32'(val);
			res.q = 32'(val);
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (entry = 0; entry < DEPTH; entry++)
				q_mem[entry] = '0;
			explore_rate = tqle_pkg::EXPLORE_RST;
			learn_rate = tqle_pkg::LEARN_RST;
			discount = tqle_pkg::DISCOUNT_RST;
			rows_in_use = tqle_pkg::ROWS_RST;
			cols_in_use = tqle_pkg::COLS_RST;
			actions_in_use = tqle_pkg::ACTIONS_RST;
			expected_responses.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tqle_pkg::CFG_EXPLORE_RATE: explore_rate = cfg_data;
					tqle_pkg::CFG_LEARN_RATE:   learn_rate = cfg_data[15:0];
					tqle_pkg::CFG_DISCOUNT:     discount = cfg_data[15:0];
					tqle_pkg::CFG_ROWS:         rows_in_use = cfg_data[4:0];
					tqle_pkg::CFG_COLS:         cols_in_use = cfg_data[4:0];
					tqle_pkg::CFG_ACTIONS:      actions_in_use = cfg_data[3:0];
					default: ;
				endcase
			end
			// check the outgoing word before queueing the incoming one
			if (out_valid && !out_stall) begin
				got.action = chosen_action;
				got.explored = explored;
				got.q = updated_q;
				got.bad = bad_request;
				if (expected_responses.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected word: action %0d explored %0d q %0d bad %0d",
							got.action, got.explored, got.q, got.bad);
					mismatches++;
				end else begin
					want = expected_responses.pop_front();
					if (got.action !== want.action || got.explored !== want.explored ||
						got.q !== want.q || got.bad !== want.bad) begin
						if (mismatches < 10)
							$display("mismatch: expected action %0d explored %0d q %0d bad %0d,",
								want.action, want.explored, want.q, want.bad,
								" got action %0d explored %0d q %0d bad %0d",
								got.action, got.explored, got.q, got.bad);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall)
				expected_responses.insert(expected_responses.size(),
					predict_response(req_type, cell_row, cell_col,
					taken_action, reward_value, next_row, next_col, uniform_draw,
					random_choice));
			pending = expected_responses.size();
		end
	end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam logic [tqle_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
	localparam logic [tqle_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [tqle_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [tqle_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                            in_valid;
	logic                            in_stall;
	logic                            req_type;
	logic [3:0]                      cell_row;
	logic [3:0]                      cell_col;
	logic [2:0]                      taken_action;
	logic signed [15:0]              reward_value;
	logic [3:0]                      next_row;
	logic [3:0]                      next_col;
	logic [15:0]                     uniform_draw;
	logic [2:0]                      random_choice;
	logic                            out_valid;
	logic                            out_stall;
	logic [2:0]                      chosen_action;
	logic                            explored;
	logic signed [31:0]              updated_q;
	logic                            bad_request;
	int                              mismatches;
	int                              pending;

	bit          idle_on;
	bit          long_hold;
	logic [16:0] cur_explore;
	int unsigned cur_rows;
	int unsigned cur_cols;
	int unsigned cur_acts;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	tabular_q_learning_engine DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.req_type      (req_type),
		.cell_row      (cell_row),
		.cell_col      (cell_col),
		.taken_action  (taken_action),
		.reward_value  (reward_value),
		.next_row      (next_row),
		.next_col      (next_col),
		.uniform_draw  (uniform_draw),
		.random_choice (random_choice),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.chosen_action (chosen_action),
		.explored      (explored),
		.updated_q     (updated_q),
		.bad_request   (bad_request)
	);

	q_engine_monitor engine_monitor (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.req_type      (req_type),
		.cell_row      (cell_row),
		.cell_col      (cell_col),
		.taken_action  (taken_action),
		.reward_value  (reward_value),
		.next_row      (next_row),
		.next_col      (next_col),
		.uniform_draw  (uniform_draw),
		.random_choice (random_choice),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.chosen_action (chosen_action),
		.explored      (explored),
		.updated_q     (updated_q),
		.bad_request   (bad_request),
		.mismatches    (mismatches),
		.pending       (pending)
	);

	// result side: random stall bursts, and one long hold on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (400) @(negedge clk);
				long_hold = 1'b0;
				out_stall <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		#5_000_000;
		$display("testbench failed");
		$finish;
	end

	task automatic write_reg(input logic [tqle_pkg::CFG_IDX_W-1:0] idx,
		input logic [tqle_pkg::CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// only with nothing in flight; narrow registers get junk in the upper bits
	task automatic configure(input logic [16:0] eps, input logic [15:0] lr,
		input logic [15:0] gamma, input logic [4:0] rows, input logic [4:0] cols,
		input logic [3:0] acts);
		logic [31:0] junk;
		junk = $urandom;
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		write_reg(tqle_pkg::CFG_EXPLORE_RATE, eps);
		write_reg(tqle_pkg::CFG_LEARN_RATE, {junk[0], lr});
		write_reg(tqle_pkg::CFG_DISCOUNT, {junk[1], gamma});
		write_reg(tqle_pkg::CFG_ROWS, {junk[13:2], rows});
		write_reg(tqle_pkg::CFG_COLS, {junk[25:14], cols});
		write_reg(tqle_pkg::CFG_ACTIONS, {junk[31:26], 7'(junk), acts});
		cur_explore = eps;
		cur_rows = (rows > 16) ? 16 : rows;
		cur_cols = (cols > 16) ? 16 : cols;
		cur_acts = (acts > 8) ? 8 : acts;
	endtask

	task automatic offer_request(input logic rq, input logic [3:0] row, input logic [3:0] col,
		input logic [2:0] act, input logic signed [15:0] reward, input logic [3:0] nxt_row,
		input logic [3:0] nxt_col, input logic [15:0] draw, input logic [2:0] pick);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rq;
		cell_row <= row;
		cell_col <= col;
		taken_action <= act;
		reward_value <= reward;
		next_row <= nxt_row;
		next_col <= nxt_col;
		uniform_draw <= draw;
		random_choice <= pick;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	task automatic ask(input logic [3:0] row, input logic [3:0] col, input logic [15:0] draw,
		input logic [2:0] pick);
		offer_request(tqle_pkg::REQ_ACTION, row, col, 3'($urandom), 16'($urandom),
			4'($urandom), 4'($urandom), draw, pick);
	endtask

	task automatic learn(input logic [3:0] row, input logic [3:0] col, input logic [2:0] act,
		input logic signed [15:0] reward, input logic [3:0] nxt_row, input logic [3:0] nxt_col);
		offer_request(tqle_pkg::REQ_UPDATE, row, col, act, reward, nxt_row, nxt_col,
			16'($urandom), 3'($urandom));
	endtask

	// mostly inside the grid in use, now and then anywhere
	function automatic logic [3:0] pick_coord(input int unsigned lim);
		if (lim != 0 && $urandom_range(0, 9) != 0)
			return 4'($urandom_range(0, lim - 1));
		return 4'($urandom);
	endfunction

	function automatic logic [2:0] pick_action(input int unsigned lim);
		if (lim != 0 && $urandom_range(0, 9) != 0)
			return 3'($urandom_range(0, lim - 1));
		return 3'($urandom);
	endfunction

	task automatic random_request();
		logic               rq;
		logic signed [15:0] reward;
		logic [15:0]        draw;
		rq = ($urandom_range(0, 99) < 55) ? tqle_pkg::REQ_UPDATE : tqle_pkg::REQ_ACTION;
		case ($urandom_range(0, 3))
			0: reward = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			1: reward = 16'($urandom_range(0, 200) - 100);
			default: reward = 16'($urandom);
		endcase
		if ($urandom_range(0, 4) == 0)
			draw = 16'(cur_explore + $urandom_range(0, 2) - 1);
		else
			draw = 16'($urandom);
		offer_request(rq, pick_coord(cur_rows), pick_coord(cur_cols), pick_action(cur_acts),
			reward, pick_coord(cur_rows), pick_coord(cur_cols), draw, pick_action(cur_acts));
	endtask

	task automatic run_phase(input logic [16:0] eps, input logic [15:0] lr,
		input logic [15:0] gamma, input logic [4:0] rows, input logic [4:0] cols,
		input logic [3:0] acts, input int count, input bit idling, input bit squeeze);
		configure(eps, lr, gamma, rows, cols, acts);
		@(posedge clk);
		idle_on = idling;
		long_hold = squeeze;
		@(negedge clk);
		repeat (count)
			random_request();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		req_type = tqle_pkg::REQ_ACTION;
		cell_row = '0;
		cell_col = '0;
		taken_action = '0;
		reward_value = '0;
		next_row = '0;
		next_col = '0;
		uniform_draw = '0;
		random_choice = '0;
		idle_on = 1'b1;
		long_hold = 1'b0;
		cur_explore = tqle_pkg::EXPLORE_RST;
		cur_rows = tqle_pkg::ROWS_RST;
		cur_cols = tqle_pkg::COLS_RST;
		cur_acts = tqle_pkg::ACTIONS_RST;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// indexes past the register list must be ignored
		write_reg(CFG_SPARE_A, 17'($urandom));
		write_reg(CFG_SPARE_B, '1);

		// reset settings: a zero rate still explores on a zero draw
		ask(4'd0, 4'd0, 16'd0, 3'd2);
		ask(4'd0, 4'd0, 16'd0, 3'd7);
		ask(4'd0, 4'd0, 16'hFFFF, 3'd0);
		learn(4'd15, 4'd15, 3'd3, 16'sh7FFF, 4'd0, 4'd0);
		learn(4'd15, 4'd15, 3'd1, 16'sh8000, 4'd15, 4'd15);
		learn(4'd15, 4'd15, 3'd2, 16'sh7FFF, 4'd15, 4'd15);
		ask(4'd15, 4'd15, 16'd1, 3'd0);
		learn(4'd15, 4'd15, 3'd4, 16'sd100, 4'd0, 4'd0);
		learn(4'd0, 4'd0, 3'd0, 16'sd0, 4'd0, 4'd0);
		ask(4'd0, 4'd0, 16'hFFFF, 3'd0);

		// small grid, always explore, fastest learning
		configure(17'h10000, 16'hFFFF, 16'hFFFF, 5'd2, 5'd3, 4'd8);
		ask(4'd2, 4'd0, 16'd0, 3'd0);
		ask(4'd0, 4'd3, 16'd0, 3'd0);
		learn(4'd0, 4'd0, 3'd1, 16'sd5, 4'd2, 4'd0);
		learn(4'd0, 4'd0, 3'd1, 16'sd5, 4'd0, 4'd3);
		ask(4'd1, 4'd2, 16'hFFFF, 3'd7);
		repeat (3)
			learn(4'd1, 4'd2, 3'd7, 16'sh7FFF, 4'd1, 4'd2);

		// one cell, one action: drive the entry to the negative limit
		configure(17'd0, 16'hFFFF, 16'hFFFF, 5'd1, 5'd1, 4'd1);
		repeat (3)
			learn(4'd0, 4'd0, 3'd0, 16'sh8000, 4'd0, 4'd0);
		ask(4'd0, 4'd0, 16'd5, 3'd3);

		run_phase(17'h04000, 16'h8000, 16'h0000, 5'd4, 5'd4, 4'd4, 250, 1'b1, 1'b0);
		run_phase(17'h00000, 16'hFFFF, 16'hFFFF, 5'd2, 5'd2, 4'd8, 250, 1'b1, 1'b0);
		run_phase(17'h10000, 16'hFFFF, 16'hFFFF, 5'd1, 5'd2, 4'd1, 150, 1'b1, 1'b0);
		run_phase(17'h1FFFF, 16'h0000, 16'h0001, 5'd31, 5'd3, 4'd15, 150, 1'b1, 1'b0);
		run_phase(17'h08000, 16'h4000, 16'h8000, 5'd0, 5'd4, 4'd3, 40, 1'b1, 1'b0);
		run_phase(17'h08000, 16'h4000, 16'h8000, 5'd5, 5'd4, 4'd0, 40, 1'b1, 1'b0);
		run_phase(17'($urandom_range(0, 70000)), 16'($urandom), 16'($urandom), 5'd1, 5'd16,
			4'd2, 200, 1'b1, 1'b0);
		run_phase(17'h08000, 16'h2000, 16'd64881, 5'd3, 5'd5, 4'd6, 250, 1'b1, 1'b1);
		run_phase(17'h01000, 16'hFFFF, 16'hFFFF, 5'd2, 5'd1, 4'd3, 300, 1'b0, 1'b0);

		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		if (mismatches == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
